[sv/rfmmq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ring FIFO with min/max query.
// Used by the controller, the datapath and the top level; depends on nothing.
package rfmmq_pkg;

	localparam int VAL_W     = 10;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 9;
	localparam int DEPTH_DEF = 256;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_QMAX = 2'd2,
		ACT_QMIN = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  front_value;
		logic [VAL_W-1:0]  back_value;
		logic              is_empty;
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  extreme_value;
		logic [CNT_W-1:0]  extreme_count;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              push;
		logic              pop;
		logic              qry_start;
		logic              qry_max;
		logic              pop_load;
		logic              scan;
		logic              finish;
		logic [STAT_W-1:0] status;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
	} dp_stat_t;

endpackage

[sv/ring_fifo_min_max_query_core.sv]
`timescale 1ns / 1ps
// Ring FIFO with min/max query: top level joining controller, datapath and store.
// Push, and any rejected or empty-queue transaction: result appears in the cycle after accept.
// Pop: result after the S_POP state, which loads the new front (one registered RAM read).
// Query: S_SCAN reads every stored entry, one stored entry per cycle through the single read port.
// The result strobe lasts one cycle and cannot be stalled; busy is low during it.
// Asynchronous reset empties the queue; store contents stay undefined until written.
module ring_fifo_min_max_query_core #(
	parameter int DEPTH = rfmmq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rfmmq_pkg::item_t   item,
	output logic               done,
	output rfmmq_pkg::result_t result
);

	rfmmq_pkg::ctl_cmd_t cmd;
	rfmmq_pkg::dp_stat_t stat;

	rfmmq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item_action(item.action),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	rfmmq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.result(result)
	);

endmodule

[sv/rfmmq_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module rfmmq_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/rfmmq_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: accepts transactions, sequences pops and scans.
// Depends on rfmmq_pkg for the command and status structs and the codes.
module rfmmq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rfmmq_pkg::ACT_W-1:0]    item_action,
	input  rfmmq_pkg::dp_stat_t            stat,
	output rfmmq_pkg::ctl_cmd_t            cmd,
	output logic                           busy,
	output logic                           done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (item_action)
						rfmmq_pkg::ACT_PUSH: begin
							cmd.finish = 1'b1;
							if (stat.full) begin
								cmd.status = rfmmq_pkg::ST_FULL;
							end else begin
								cmd.push   = 1'b1;
								cmd.status = rfmmq_pkg::ST_OK;
							end
						end
						rfmmq_pkg::ACT_POP: begin
							if (stat.empty) begin
								cmd.finish = 1'b1;
								cmd.status = rfmmq_pkg::ST_EMPTY;
							end else begin
								cmd.pop = 1'b1;
								state_d = S_POP;
							end
						end
						rfmmq_pkg::ACT_QMAX, rfmmq_pkg::ACT_QMIN: begin
							if (stat.empty) begin
								cmd.finish = 1'b1;
								cmd.status = rfmmq_pkg::ST_OK;
							end else begin
								cmd.qry_start = 1'b1;
								cmd.qry_max   = (item_action == rfmmq_pkg::ACT_QMAX);
								state_d       = S_SCAN;
							end
						end
						default: begin
							cmd.finish = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				// The new front entry arrives from the RAM in this cycle.
				cmd.pop_load = 1'b1;
				cmd.finish   = 1'b1;
				cmd.status   = rfmmq_pkg::ST_OK;
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.status = rfmmq_pkg::ST_OK;
				if (stat.scan_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= cmd.finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while a transaction is still in progress");

	a_pop_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && item_action == rfmmq_pkg::ACT_POP && !stat.empty)
		|=> (state_q == S_POP))
		else $error("pop on a non-empty queue did not enter the load state");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> (done_q && state_q == S_IDLE))
		else $error("pop load did not complete in one cycle");

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q == (state_q != S_IDLE)))
		else $error("busy does not track the controller state");

endmodule

[sv/rfmmq_dp.sv]
`timescale 1ns / 1ps
// Datapath: ring pointers, occupancy, front/back registers, scan unit and store.
// Depends on rfmmq_pkg and instantiates rfmmq_ram.
module rfmmq_dp #(
	parameter int DEPTH = rfmmq_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rfmmq_pkg::item_t    item,
	input  rfmmq_pkg::ctl_cmd_t cmd,
	output rfmmq_pkg::dp_stat_t stat,
	output rfmmq_pkg::result_t  result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam int VW = rfmmq_pkg::VAL_W;
	localparam int CW = rfmmq_pkg::CNT_W;

	logic [AW-1:0]                  head_q;
	logic [AW-1:0]                  tail_q;
	logic [OW-1:0]                  occ_q;
	logic [VW-1:0]                  front_q;
	logic [VW-1:0]                  back_q;
	logic [AW-1:0]                  scan_ptr_q;
	logic [OW-1:0]                  scan_idx_q;
	logic                           qry_max_q;
	logic [rfmmq_pkg::STAT_W-1:0]   status_q;
	logic [VW-1:0]                  ext_val_q;
	logic [CW-1:0]                  ext_cnt_q;

	logic [AW-1:0] head_inc;
	logic [AW-1:0] raddr;
	logic [VW-1:0] rdata;
	logic [VW-1:0] ext_val_d;
	logic [CW-1:0] ext_cnt_d;
	logic          better;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	assign head_inc = ring_inc(head_q);

	// A pop fetches the entry behind the current front; a query starts at the front.
	always_comb begin
		if (cmd.pop) begin
			raddr = head_inc;
		end else if (cmd.qry_start) begin
			raddr = head_q;
		end else begin
			raddr = scan_ptr_q;
		end
	end

	rfmmq_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(tail_q),
		.wdata(item.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Running extreme: the first entry seeds it, later ones replace or count.
	always_comb begin
		better = qry_max_q ? (rdata > ext_val_q) : (rdata < ext_val_q);
		if (scan_idx_q == '0 || better) begin
			ext_val_d = rdata;
			ext_cnt_d = CW'(1);
		end else if (rdata == ext_val_q) begin
			ext_val_d = ext_val_q;
			ext_cnt_d = ext_cnt_q + CW'(1);
		end else begin
			ext_val_d = ext_val_q;
			ext_cnt_d = ext_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			scan_idx_q <= '0;
			status_q   <= rfmmq_pkg::ST_OK;
		end else begin
			if (cmd.push) begin
				tail_q <= ring_inc(tail_q);
				occ_q  <= occ_q + OW'(1);
			end
			if (cmd.pop) begin
				head_q <= head_inc;
				occ_q  <= occ_q - OW'(1);
			end
			if (cmd.qry_start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + OW'(1);
			end
			if (cmd.finish) begin
				status_q <= cmd.status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			back_q <= item.value;
			if (occ_q == '0) begin
				front_q <= item.value;
			end
		end
		if (cmd.pop_load) begin
			front_q <= rdata;
		end
		if (cmd.qry_start) begin
			scan_ptr_q <= head_inc;
			qry_max_q  <= cmd.qry_max;
		end else if (cmd.scan) begin
			scan_ptr_q <= ring_inc(scan_ptr_q);
		end
		if (cmd.scan) begin
			ext_val_q <= ext_val_d;
			ext_cnt_q <= ext_cnt_d;
		end else if (cmd.finish) begin
			ext_val_q <= '0;
			ext_cnt_q <= '0;
		end
	end

	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q == OW'(DEPTH));
	assign stat.scan_last = (scan_idx_q == occ_q - OW'(1));

	assign result.front_value   = stat.empty ? '0 : front_q;
	assign result.back_value    = stat.empty ? '0 : back_q;
	assign result.is_empty      = stat.empty;
	assign result.status        = status_q;
	assign result.extreme_value = ext_val_q;
	assign result.extreme_count = ext_cnt_q;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy exceeds the queue depth");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> $past(cmd.push || cmd.pop))
		else $error("occupancy changed without a push or pop");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("write issued to a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("pop issued on an empty queue");

endmodule
